// ----- src/srsc_pkg.sv -----
`default_nettype none

package srsc_pkg;

  // Field widths
  localparam int unsigned RAW_W     = 12;
  localparam int unsigned WATER_W   = 7;
  localparam int unsigned SUCTION_W = 15;
  localparam int unsigned PROD_W    = RAW_W + WATER_W;

  // One divider step per quotient bit
  localparam int unsigned DIV_STEPS = WATER_W;

  // Register file
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam logic [1:0] REG_RAW_DRY       = 2'd0;
  localparam logic [1:0] REG_RAW_SATURATED = 2'd1;
  localparam logic [1:0] REG_MAX_WATER_PCT = 2'd2;

  localparam logic [RAW_W-1:0]   RAW_DRY_RST       = RAW_W'(3000);
  localparam logic [RAW_W-1:0]   RAW_SATURATED_RST = RAW_W'(1200);
  localparam logic [WATER_W-1:0] MAX_WATER_PCT_RST = WATER_W'(50);

  // Retention curve: water in hundredths against kPa
  localparam int unsigned TABLE_POINTS = 8;
  localparam int unsigned CURVE_WATER [TABLE_POINTS] = '{50, 46, 42, 38, 35, 31, 25, 22};
  localparam int unsigned CURVE_KPA   [TABLE_POINTS] = '{1, 10, 30, 80, 200, 500, 1000, 1500};

  localparam int unsigned LUT_DEPTH = 1 << WATER_W;

  typedef logic [LUT_DEPTH-1:0][SUCTION_W-1:0] suction_lut_t;

  // Divider stage payload
  typedef struct packed {
    logic               byp;
    logic [WATER_W-1:0] byp_val;
    logic [PROD_W-1:0]  rem;
    logic [RAW_W-1:0]   den;
    logic [WATER_W-1:0] quo;
  } div_t;

  // Shift-and-subtract quotient, used only while building the curve table
  function automatic int unsigned const_quotient(int unsigned num, int unsigned den);
    int unsigned q;
    int unsigned r;
    q = 0;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      r = (r << 1) | ((num >> b) & 32'd1);
      if (r >= den) begin
        r = r - den;
        q = q | (32'd1 << b);
      end
    end
    return q;
  endfunction

  // Evaluate the interpolated curve for every water value at elaboration
  function automatic suction_lut_t build_suction_lut();
    suction_lut_t lut;
    int unsigned  v1;
    int unsigned  v2;
    int unsigned  k1;
    int unsigned  k2;
    int unsigned  s;
    lut = '0;
    for (int unsigned w = 0; w < LUT_DEPTH; w++) begin
      if (w >= CURVE_WATER[0]) begin
        s = CURVE_KPA[0] * 16;
      end else if (w <= CURVE_WATER[TABLE_POINTS-1]) begin
        s = CURVE_KPA[TABLE_POINTS-1] * 16;
      end else begin
        s = CURVE_KPA[TABLE_POINTS-1] * 16;
        for (int i = TABLE_POINTS - 2; i >= 0; i--) begin
          v1 = CURVE_WATER[i];
          v2 = CURVE_WATER[i+1];
          k1 = CURVE_KPA[i];
          k2 = CURVE_KPA[i+1];
          if (w <= v1 && w > v2 && v1 > v2 && k2 >= k1) begin
            s = k1 * 16 + const_quotient((v1 - w) * (k2 - k1) * 16, v1 - v2);
          end
        end
      end
      lut[w] = SUCTION_W'(s);
    end
    return lut;
  endfunction

  localparam suction_lut_t SUCTION_LUT = build_suction_lut();

endpackage

`default_nettype wire

// ----- src/soil_raw_to_suction_converter.sv -----
// Channel  Handshake                Payload
// in       in_valid / in_stall      in_raw_sample[11:0]
// out      out_valid / out_stall    out_water_pct[6:0], out_suction_q4[14:0]
// cfg      psel/penable/pwrite      paddr[3:0], pwdata[31:0], prdata[31:0], pready
//
// One transaction enters per cycle while the output is not stalled; each one passes in order
// through the clamp stage, the multiply stage, seven restoring divider stages (one quotient
// bit each) and the curve lookup stage.
// Reset clears all valid bits and loads the calibration registers with their defaults.
// A stalled result freezes the whole pipeline and raises in_stall in the same cycle.
`default_nettype none

module soil_raw_to_suction_converter (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [srsc_pkg::RAW_W-1:0]       in_raw_sample,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [srsc_pkg::WATER_W-1:0]          out_water_pct,
  output logic [srsc_pkg::SUCTION_W-1:0]        out_suction_q4,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [srsc_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [srsc_pkg::DATA_W-1:0]      pwdata,
  output logic [srsc_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready
);

  localparam int unsigned RAW_W   = srsc_pkg::RAW_W;
  localparam int unsigned WATER_W = srsc_pkg::WATER_W;
  localparam int unsigned PROD_W  = srsc_pkg::PROD_W;
  localparam int unsigned STEPS   = srsc_pkg::DIV_STEPS;

  // Configuration registers
  logic [RAW_W-1:0]   raw_dry_r;
  logic [RAW_W-1:0]   raw_sat_r;
  logic [WATER_W-1:0] max_water_r;
  logic               cfg_wr;
  logic [1:0]         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_dry_r   <= srsc_pkg::RAW_DRY_RST;
      raw_sat_r   <= srsc_pkg::RAW_SATURATED_RST;
      max_water_r <= srsc_pkg::MAX_WATER_PCT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        srsc_pkg::REG_RAW_DRY:       raw_dry_r   <= pwdata[RAW_W-1:0];
        srsc_pkg::REG_RAW_SATURATED: raw_sat_r   <= pwdata[RAW_W-1:0];
        srsc_pkg::REG_MAX_WATER_PCT: max_water_r <= pwdata[WATER_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (cfg_idx)
      srsc_pkg::REG_RAW_DRY:       prdata = {(32 - RAW_W)'(0), raw_dry_r};
      srsc_pkg::REG_RAW_SATURATED: prdata = {(32 - RAW_W)'(0), raw_sat_r};
      srsc_pkg::REG_MAX_WATER_PCT: prdata = {(32 - WATER_W)'(0), max_water_r};
      default:                     prdata = '0;
    endcase
  end

  // Pipeline advance: hold everything while the output is stalled
  logic adv;
  logic in_acc;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign in_acc   = in_valid && !in_stall;

  // Stage 1: clamp and pick the divisor
  logic               s1_vld_r;
  logic               s1_byp_r,     s1_byp_nxt;
  logic [WATER_W-1:0] s1_byp_val_r, s1_byp_val_nxt;
  logic [RAW_W-1:0]   s1_diff_r,    s1_diff_nxt;
  logic [RAW_W-1:0]   s1_den_r,     s1_den_nxt;
  logic [WATER_W-1:0] s1_max_r;
  logic [RAW_W-1:0]   clamped;

  always_comb begin
    if (in_raw_sample < raw_sat_r) begin
      clamped = raw_sat_r;
    end else if (in_raw_sample > raw_dry_r) begin
      clamped = raw_dry_r;
    end else begin
      clamped = in_raw_sample;
    end
    s1_diff_nxt    = raw_dry_r - clamped;
    s1_den_nxt     = raw_dry_r - raw_sat_r;
    s1_byp_nxt     = 1'b0;
    s1_byp_val_nxt = '0;
    // Equal counts give zero; inverted counts give either end of the range
    if (raw_sat_r == raw_dry_r) begin
      s1_byp_nxt = 1'b1;
    end else if (raw_sat_r > raw_dry_r) begin
      s1_byp_nxt     = 1'b1;
      s1_byp_val_nxt = (in_raw_sample < raw_sat_r) ? max_water_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_byp_r     <= s1_byp_nxt;
      s1_byp_val_r <= s1_byp_val_nxt;
      s1_diff_r    <= s1_diff_nxt;
      s1_den_r     <= s1_den_nxt;
      s1_max_r     <= max_water_r;
    end
  end

  // Stage 2: scale the distance from dry by the saturation water content
  srsc_pkg::div_t dv_r   [STEPS+1];
  srsc_pkg::div_t dv_nxt [STEPS+1];
  logic           dv_vld_r [STEPS+1];

  always_comb begin
    dv_nxt[0].byp     = s1_byp_r;
    dv_nxt[0].byp_val = s1_byp_val_r;
    dv_nxt[0].rem     = PROD_W'(s1_diff_r) * PROD_W'(s1_max_r);
    dv_nxt[0].den     = s1_den_r;
    dv_nxt[0].quo     = '0;
  end

  // Stages 3 to 9: restoring divide, most significant quotient bit first
  for (genvar j = 1; j <= STEPS; j++) begin : g_div
    localparam int unsigned SH = STEPS - j;
    logic [PROD_W-1:0] sub;
    always_comb begin
      sub       = PROD_W'(dv_r[j-1].den) << SH;
      dv_nxt[j] = dv_r[j-1];
      if (dv_r[j-1].rem >= sub) begin
        dv_nxt[j].rem     = dv_r[j-1].rem - sub;
        dv_nxt[j].quo[SH] = 1'b1;
      end
    end
  end

  for (genvar j = 0; j <= STEPS; j++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[j] <= 1'b0;
      end else if (adv) begin
        dv_vld_r[j] <= (j == 0) ? s1_vld_r : dv_vld_r[(j == 0) ? 0 : j-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[j] <= dv_nxt[j];
      end
    end
  end

  // Stage 10: select water content and look up suction
  logic [WATER_W-1:0]            water;
  logic                          out_valid_r;
  logic [WATER_W-1:0]            out_water_r;
  logic [srsc_pkg::SUCTION_W-1:0] out_suction_r;

  assign water = dv_r[STEPS].byp ? dv_r[STEPS].byp_val : dv_r[STEPS].quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_vld_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_water_r   <= water;
      out_suction_r <= srsc_pkg::SUCTION_LUT[water];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_water_pct  = out_water_r;
  assign out_suction_q4 = out_suction_r;

  // Checks
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_vld_r[STEPS] && !dv_r[STEPS].byp) |->
      (dv_r[STEPS].rem < PROD_W'(dv_r[STEPS].den)))
    else $error("divider remainder not below divisor");

  a_suction_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_suction_r >= 15'd16 && out_suction_r <= 15'd24000))
    else $error("suction outside curve range");

  a_water_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_vld_r[STEPS] && !dv_r[STEPS].byp) |-> (dv_r[STEPS].quo <= max_water_r))
    else $error("water content above saturation value");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(dv_r[STEPS]) && $stable(dv_vld_r[STEPS])))
    else $error("pipeline moved during output stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_vld_r)
    else $error("accepted transaction missing from first stage");

endmodule

`default_nettype wire
